// File: rtl/core/nfba_pkg.sv
// Shared types, constants and helpers for the next-fit block allocator.
package nfba_pkg;

    localparam int SPACE_SIZE  = 1024;
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = 10;
    localparam int SIZE_W      = 11;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_ALREADY   = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              used;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    localparam rec_t REC0_RESET = '{start: '0, size: SIZE_W'(SPACE_SIZE), used: 1'b0};

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] granted_address;
    } rsp_t;

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i,
                                                   input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] nx;
        nx = CNT_W'(i) + CNT_W'(1);
        return (nx >= len) ? '0 : nx[IDX_W-1:0];
    endfunction

endpackage

// File: rtl/core/nfba_req_if.sv
// Request channel: valid/ready with the allocate or free beat.
interface nfba_req_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [nfba_pkg::SIZE_W-1:0] req_size;
    logic [nfba_pkg::ADDR_W-1:0] block_address;

    modport source (output valid, kind, req_size, block_address, input ready);
    modport sink   (input valid, kind, req_size, block_address, output ready);
endinterface

// File: rtl/core/nfba_rsp_if.sv
// Response channel: valid/ready with the status beat.
interface nfba_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [nfba_pkg::ADDR_W-1:0] granted_address;

    modport source (output valid, status, granted_address, input ready);
    modport sink   (input valid, status, granted_address, output ready);
endinterface

// File: rtl/core/nfba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/nfba_ctrl.sv
// Request sequencer: scans the record RAM, splits, marks and moves the cursor.
module nfba_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [nfba_pkg::SIZE_W-1:0] split_tolerance,
    nfba_req_if.sink                    req,
    output logic                        res_valid,
    input  logic                        res_ready,
    output nfba_pkg::rsp_t              res
);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WR_HIT, S_WR_NEW, S_RES} state_t;
    typedef enum logic [1:0] {M_ALLOC, M_CURS, M_FREE} mode_t;

    state_t                        state_reg;
    mode_t                         mode_reg;
    logic [nfba_pkg::CNT_W-1:0]    cnt_reg;
    logic [nfba_pkg::IDX_W-1:0]    cursor_reg;
    logic                          rec0_init_reg;
    logic [nfba_pkg::IDX_W-1:0]    iss_idx_reg;
    logic                          iss_done_reg;
    logic [nfba_pkg::IDX_W-1:0]    chk_idx_reg;
    logic                          chk_vld_reg;
    logic [nfba_pkg::IDX_W-1:0]    stop_idx_reg;
    logic [nfba_pkg::IDX_W-1:0]    start_cur_reg;
    logic [nfba_pkg::IDX_W-1:0]    hit_idx_reg;
    nfba_pkg::rec_t                hit_rec_reg;
    logic                          split_reg;
    logic [nfba_pkg::SIZE_W-1:0]   n_reg;
    logic [nfba_pkg::ADDR_W-1:0]   addr_reg;
    nfba_pkg::rsp_t                res_reg;

    logic                          ram_we;
    logic [nfba_pkg::IDX_W-1:0]    ram_waddr;
    nfba_pkg::rec_t                ram_wdata;
    logic [nfba_pkg::REC_W-1:0]    ram_rdata;
    nfba_pkg::rec_t                rd_rec;
    logic                          pred;
    logic                          match;
    logic [nfba_pkg::IDX_W-1:0]    iss_next;
    logic [nfba_pkg::CNT_W-1:0]    cnt_next;
    logic [nfba_pkg::IDX_W-1:0]    curs_first;
    logic [nfba_pkg::IDX_W-1:0]    start_cur_next;
    logic [nfba_pkg::SIZE_W:0]     split_lim;

    nfba_ram #(.WIDTH(nfba_pkg::REC_W), .DEPTH(nfba_pkg::TABLE_DEPTH)) u_rec_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (iss_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        rd_rec = (chk_idx_reg == '0 && rec0_init_reg) ? nfba_pkg::REC0_RESET
                                                       : nfba_pkg::rec_t'(ram_rdata);
        case (mode_reg)
            M_ALLOC: pred = !rd_rec.used && rd_rec.size >= n_reg;
            M_CURS:  pred = !rd_rec.used;
            M_FREE:  pred = rd_rec.start == addr_reg;
            default: pred = 1'b0;
        endcase
        match          = (state_reg == S_SCAN) && chk_vld_reg && pred;
        iss_next       = nfba_pkg::wrap_next(iss_idx_reg, cnt_reg);
        split_lim      = {1'b0, n_reg} + {1'b0, split_tolerance};
        cnt_next       = (state_reg == S_WR_NEW) ? cnt_reg + nfba_pkg::CNT_W'(1) : cnt_reg;
        curs_first     = nfba_pkg::wrap_next(hit_idx_reg, cnt_next);
        start_cur_next = (nfba_pkg::CNT_W'(cursor_reg) < cnt_reg) ? cursor_reg : '0;

        ram_we    = 1'b0;
        ram_waddr = hit_idx_reg;
        ram_wdata = hit_rec_reg;
        case (state_reg)
            S_WR_HIT:
            begin
                ram_we = 1'b1;
                if (mode_reg == M_FREE)
                begin
                    ram_wdata.used = 1'b0;
                end
                else
                begin
                    ram_wdata.used = 1'b1;
                    if (split_reg)
                    begin
                        ram_wdata.size = n_reg;
                    end
                end
            end
            S_WR_NEW:
            begin
                ram_we          = 1'b1;
                ram_waddr       = cnt_reg[nfba_pkg::IDX_W-1:0];
                ram_wdata.start = hit_rec_reg.start + n_reg[nfba_pkg::ADDR_W-1:0];
                ram_wdata.size  = hit_rec_reg.size - n_reg;
                ram_wdata.used  = 1'b0;
            end
            default: ;
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RES);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_ALLOC;
            cnt_reg       <= nfba_pkg::CNT_W'(1);
            cursor_reg    <= '0;
            rec0_init_reg <= 1'b1;
            iss_idx_reg   <= '0;
            iss_done_reg  <= 1'b0;
            chk_idx_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            stop_idx_reg  <= '0;
            start_cur_reg <= '0;
            hit_idx_reg   <= '0;
            hit_rec_reg   <= nfba_pkg::REC0_RESET;
            split_reg     <= 1'b0;
            n_reg         <= '0;
            addr_reg      <= '0;
            res_reg       <= '0;
        end
        else
        begin
            if (ram_we && ram_waddr == '0)
            begin
                rec0_init_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        n_reg        <= req.req_size;
                        addr_reg     <= req.block_address;
                        res_reg      <= '{status: nfba_pkg::ST_NO_FIT, granted_address: '0};
                        iss_done_reg <= 1'b0;
                        chk_vld_reg  <= 1'b0;
                        if (req.kind == nfba_pkg::KIND_FREE)
                        begin
                            mode_reg     <= M_FREE;
                            iss_idx_reg  <= '0;
                            stop_idx_reg <= '0;
                            state_reg    <= S_SCAN;
                        end
                        else if (req.req_size == '0)
                        begin
                            state_reg <= S_RES;
                        end
                        else
                        begin
                            mode_reg      <= M_ALLOC;
                            start_cur_reg <= start_cur_next;
                            iss_idx_reg   <= start_cur_next;
                            stop_idx_reg  <= start_cur_next;
                            state_reg     <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (match)
                    begin
                        chk_vld_reg <= 1'b0;
                        hit_idx_reg <= chk_idx_reg;
                        hit_rec_reg <= rd_rec;
                        case (mode_reg)
                            M_ALLOC:
                            begin
                                split_reg <= ({1'b0, rd_rec.size} > split_lim) &&
                                             (cnt_reg != nfba_pkg::CNT_W'(nfba_pkg::TABLE_DEPTH));
                                res_reg   <= '{status: nfba_pkg::ST_DONE,
                                               granted_address: rd_rec.start};
                                state_reg <= S_WR_HIT;
                            end
                            M_CURS:
                            begin
                                cursor_reg <= chk_idx_reg;
                                state_reg  <= S_RES;
                            end
                            default:
                            begin
                                if (rd_rec.used)
                                begin
                                    cursor_reg <= chk_idx_reg;
                                    res_reg    <= '{status: nfba_pkg::ST_DONE,
                                                    granted_address: '0};
                                    state_reg  <= S_WR_HIT;
                                end
                                else
                                begin
                                    res_reg   <= '{status: nfba_pkg::ST_ALREADY,
                                                   granted_address: '0};
                                    state_reg <= S_RES;
                                end
                            end
                        endcase
                    end
                    else if (chk_vld_reg && iss_done_reg)
                    begin
                        chk_vld_reg <= 1'b0;
                        if (mode_reg == M_FREE)
                        begin
                            res_reg <= '{status: nfba_pkg::ST_NOT_FOUND, granted_address: '0};
                        end
                        state_reg <= S_RES;
                    end
                    else if (!iss_done_reg)
                    begin
                        chk_idx_reg  <= iss_idx_reg;
                        chk_vld_reg  <= 1'b1;
                        iss_idx_reg  <= iss_next;
                        iss_done_reg <= (iss_next == stop_idx_reg);
                    end
                    else
                    begin
                        state_reg <= S_RES;
                    end
                end
                S_WR_HIT:
                begin
                    if (mode_reg == M_FREE)
                    begin
                        state_reg <= S_RES;
                    end
                    else if (split_reg)
                    begin
                        state_reg <= S_WR_NEW;
                    end
                    else if (curs_first == start_cur_reg)
                    begin
                        state_reg <= S_RES;
                    end
                    else
                    begin
                        mode_reg     <= M_CURS;
                        iss_idx_reg  <= curs_first;
                        stop_idx_reg <= start_cur_reg;
                        iss_done_reg <= 1'b0;
                        chk_vld_reg  <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_WR_NEW:
                begin
                    cnt_reg <= cnt_next;
                    if (curs_first == start_cur_reg)
                    begin
                        state_reg <= S_RES;
                    end
                    else
                    begin
                        mode_reg     <= M_CURS;
                        iss_idx_reg  <= curs_first;
                        stop_idx_reg <= start_cur_reg;
                        iss_done_reg <= 1'b0;
                        chk_vld_reg  <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_RES:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg >= nfba_pkg::CNT_W'(1) &&
        cnt_reg <= nfba_pkg::CNT_W'(nfba_pkg::TABLE_DEPTH))
        else $error("record count out of range");

    a_cursor_live: assert property (@(posedge clk) disable iff (!rst_n)
        nfba_pkg::CNT_W'(cursor_reg) < cnt_reg)
        else $error("cursor beyond live records");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR_NEW |-> cnt_reg < nfba_pkg::CNT_W'(nfba_pkg::TABLE_DEPTH))
        else $error("append into a full table");

    a_cnt_grows_on_append: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != $past(cnt_reg) |-> $past(state_reg) == S_WR_NEW)
        else $error("record count changed outside an append");

endmodule

// File: rtl/core/next_fit_block_allocator.sv
// Next-fit block allocator: tolerance register, response buffer and sequencer.
// One record is read a cycle while a request scans the record RAM.
// A zero-size allocate answers without a scan; a free scans from record 0 upward.
// Throughput: one request at a time; the sequencer takes a request only while idle.
// Reset: one free record covering the whole space, cursor 0, tolerance 0; no clearing pass.
module next_fit_block_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [nfba_pkg::SIZE_W-1:0] cfg_wdata,
    nfba_req_if.sink                    req,
    nfba_rsp_if.source                  rsp
);

    logic [nfba_pkg::SIZE_W-1:0] tol_reg;
    logic                        out_vld_reg;
    nfba_pkg::rsp_t              out_reg;
    logic                        res_valid;
    logic                        res_ready;
    nfba_pkg::rsp_t              res;

    nfba_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .split_tolerance (tol_reg),
        .req             (req),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    assign res_ready           = !out_vld_reg || rsp.ready;
    assign rsp.valid           = out_vld_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.granted_address = out_reg.granted_address;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg     <= '0;
            out_vld_reg <= 1'b0;
            out_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            if (res_ready)
            begin
                out_vld_reg <= res_valid;
                if (res_valid)
                begin
                    out_reg <= res;
                end
            end
        end
    end

endmodule

// File: verif/nfba_checker.sv
// Allocator checker: predicts each response from the request beats and compares.
`timescale 1ns / 1ps

module nfba_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [nfba_pkg::SIZE_W-1:0] cfg_wdata,
    nfba_req_if.sink                    req_mon,
    nfba_rsp_if.sink                    rsp_mon,
    output int                          fail_count,
    output int                          pending,
    output int                          checked_count
);

    logic [nfba_pkg::ADDR_W-1:0] blk_start [nfba_pkg::TABLE_DEPTH];
    logic [nfba_pkg::SIZE_W-1:0] blk_size  [nfba_pkg::TABLE_DEPTH];
    logic                        blk_used  [nfba_pkg::TABLE_DEPTH];
    int                          blk_count;
    int                          cursor;
    int                          tolerance;
    nfba_pkg::rsp_t              awaited_rsp [$];

    function automatic int step_idx(int i, int len);
        return (i + 1 >= len) ? 0 : i + 1;
    endfunction

    function automatic nfba_pkg::rsp_t allocate_block(int n);
        nfba_pkg::rsp_t r;
        int   len;
        int   first;
        int   i;
        bit   hit;
        r = '{status: nfba_pkg::ST_NO_FIT, granted_address: '0};
        len = blk_count;
        hit = 0;
        if (n == 0)
            return r;
        first = (cursor < len) ? cursor : 0;
        i = first;
        forever
        begin
            if (!blk_used[i] && int'(blk_size[i]) >= n)
            begin
                hit = 1;
                break;
            end
            i = step_idx(i, len);
            if (i == first)
                break;
        end
        if (!hit)
            return r;
        if (int'(blk_size[i]) <= n + tolerance || len >= nfba_pkg::TABLE_DEPTH)
            blk_used[i] = 1'b1;
        else
        begin
            blk_start[len] = blk_start[i] + nfba_pkg::ADDR_W'(n);
            blk_size[len]  = blk_size[i] - nfba_pkg::SIZE_W'(n);
            blk_used[len]  = 1'b0;
            len++;
            blk_count = len;
            blk_size[i] = nfba_pkg::SIZE_W'(n);
            blk_used[i] = 1'b1;
        end
        r.status = nfba_pkg::ST_DONE;
        r.granted_address = blk_start[i];
        forever
        begin
            if (!blk_used[i])
            begin
                cursor = i;
                break;
            end
            i = step_idx(i, len);
            if (i == first)
                break;
        end
        return r;
    endfunction

    function automatic nfba_pkg::rsp_t release_block(logic [nfba_pkg::ADDR_W-1:0] a);
        nfba_pkg::rsp_t r;
        r = '{status: nfba_pkg::ST_NOT_FOUND, granted_address: '0};
        for (int i = 0; i < blk_count; i++)
        begin
            if (blk_start[i] != a)
                continue;
            if (!blk_used[i])
                r.status = nfba_pkg::ST_ALREADY;
            else
            begin
                blk_used[i] = 1'b0;
                cursor = i;
                r.status = nfba_pkg::ST_DONE;
            end
            return r;
        end
        return r;
    endfunction

    assign pending = awaited_rsp.size();

    always @(posedge clk or negedge rst_n)
    begin
        nfba_pkg::rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < nfba_pkg::TABLE_DEPTH; i++)
            begin
                blk_start[i] = '0;
                blk_size[i]  = '0;
                blk_used[i]  = 1'b0;
            end
            blk_size[0] = nfba_pkg::SIZE_W'(nfba_pkg::SPACE_SIZE);
            blk_count = 1;
            cursor = 0;
            tolerance = 0;
            awaited_rsp.delete();
            fail_count <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (cfg_we)
                tolerance = int'(cfg_wdata);
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                checked_count <= checked_count + 1;
                if (awaited_rsp.size() == 0)
                begin
                    $error("response beat with nothing awaited");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp_mon.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                        fail_count <= fail_count + 1;
                    end
                    else if (rsp_mon.granted_address !== want.granted_address)
                    begin
                        $error("granted_address: expected %0d, got %0d",
                               want.granted_address, rsp_mon.granted_address);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req_mon.valid && req_mon.ready)
            begin
                if (req_mon.kind == nfba_pkg::KIND_ALLOC)
                    awaited_rsp.push_back(allocate_block(int'(req_mon.req_size)));
                else
                    awaited_rsp.push_back(release_block(req_mon.block_address));
            end
        end
    end

endmodule

// File: verif/testbench.sv
// Testbench top: clock, reset, request stimulus, response back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [nfba_pkg::SIZE_W-1:0] cfg_wdata;
    int                          fail_count;
    int                          pending;
    int                          checked_count;
    int                          gap_pct;
    int                          stall_pct;
    int                          n_alloc;
    int                          n_free;
    logic [nfba_pkg::ADDR_W-1:0] granted_list [$];

    nfba_req_if req ();
    nfba_rsp_if rsp ();

    next_fit_block_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    nfba_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req_mon       (req.sink),
        .rsp_mon       (rsp.sink),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
        if (rsp.valid && rsp.ready && rsp.status == nfba_pkg::ST_DONE &&
            rsp.granted_address != '0)
            granted_list.push_back(rsp.granted_address);
    end

    task automatic send_beat(logic k, logic [nfba_pkg::SIZE_W-1:0] sz,
                             logic [nfba_pkg::ADDR_W-1:0] a);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.kind          <= k;
        req.req_size      <= sz;
        req.block_address <= a;
        if (k == nfba_pkg::KIND_ALLOC)
            n_alloc++;
        else
            n_free++;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        wait (pending == 0);
        repeat (2 * nfba_pkg::TABLE_DEPTH + 20) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [nfba_pkg::SIZE_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_beat();
        int pick;
        logic [nfba_pkg::ADDR_W-1:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            send_beat(nfba_pkg::KIND_ALLOC, nfba_pkg::SIZE_W'($urandom_range(1, 48)), '0);
        else if (pick < 56)
            send_beat(nfba_pkg::KIND_ALLOC, nfba_pkg::SIZE_W'($urandom_range(0, 2047)),
                      nfba_pkg::ADDR_W'($urandom));
        else if (pick < 88 && granted_list.size() > 0)
        begin
            pick = $urandom_range(0, granted_list.size() - 1);
            a = granted_list[pick];
            granted_list.delete(pick);
            send_beat(nfba_pkg::KIND_FREE, nfba_pkg::SIZE_W'($urandom), a);
        end
        else
            send_beat(nfba_pkg::KIND_FREE, nfba_pkg::SIZE_W'($urandom),
                      nfba_pkg::ADDR_W'($urandom));
    endtask

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.kind = nfba_pkg::KIND_ALLOC;
        req.req_size = '0;
        req.block_address = '0;
        rsp.ready = 1'b0;
        gap_pct = 11;
        stall_pct = 48;
        n_alloc = 0;
        n_free = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(nfba_pkg::KIND_ALLOC, 11'd0, '0);
        send_beat(nfba_pkg::KIND_ALLOC, 11'd2047, '1);
        send_beat(nfba_pkg::KIND_ALLOC, 11'd1025, '0);
        send_beat(nfba_pkg::KIND_FREE, '0, 10'd1023);
        send_beat(nfba_pkg::KIND_ALLOC, 11'd1024, '0);
        send_beat(nfba_pkg::KIND_ALLOC, 11'd1, '0);
        send_beat(nfba_pkg::KIND_FREE, '0, 10'd0);
        send_beat(nfba_pkg::KIND_FREE, '0, 10'd0);
        send_beat(nfba_pkg::KIND_ALLOC, 11'd1, '0);
        send_beat(nfba_pkg::KIND_ALLOC, 11'd512, '0);
        send_beat(nfba_pkg::KIND_ALLOC, 11'd511, '0);
        send_beat(nfba_pkg::KIND_ALLOC, 11'd1, '0);
        send_beat(nfba_pkg::KIND_FREE, 11'h7FF, 10'd1);
        send_beat(nfba_pkg::KIND_ALLOC, 11'd1, '0);
        send_beat(nfba_pkg::KIND_FREE, '0, 10'd513);
        send_beat(nfba_pkg::KIND_FREE, '0, 10'd1);
        send_beat(nfba_pkg::KIND_ALLOC, 11'd600, '0);
        send_beat(nfba_pkg::KIND_ALLOC, 11'd400, '0);
        drain();
        granted_list.delete();

        write_tolerance(11'd1024);
        for (int i = 0; i < 300; i++)
            random_beat();
        drain();
        write_tolerance(11'd8);
        gap_pct = 48;
        stall_pct = 11;
        for (int i = 0; i < 300; i++)
            random_beat();
        drain();
        write_tolerance(11'd2047);
        for (int i = 0; i < 150; i++)
            random_beat();
        drain();
        write_tolerance(11'd0);
        gap_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < 450; i++)
            random_beat();
        drain();

        $display("covered %0d allocate and %0d free beats at four tolerance settings",
                 n_alloc, n_free);
        $display("%0d response beats checked, %0d mismatches", checked_count, fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/nfba_pkg.sv
rtl/core/nfba_req_if.sv
rtl/core/nfba_rsp_if.sv
rtl/core/nfba_ram.sv
rtl/core/nfba_ctrl.sv
rtl/core/next_fit_block_allocator.sv
verif/nfba_checker.sv
verif/testbench.sv
